@@ design/amet_pkg.sv @@
// Package for the adaptive maze edge tracer: sizes, state codes and heading tables.
package amet_pkg;

  localparam int MAX_WIDTH  = 320;
  localparam int MAX_HEIGHT = 240;
  localparam int MAX_POINTS = 64;
  localparam int MAX_BLOCK  = 15;

  localparam int ADDR_W  = $clog2(MAX_WIDTH * MAX_HEIGHT);
  localparam int DEPTH   = MAX_WIDTH * MAX_HEIGHT;
  localparam int SUM_W   = $clog2(MAX_BLOCK * MAX_BLOCK * 255 + 1);
  localparam int DIV_W   = $clog2(MAX_BLOCK * MAX_BLOCK + 1);
  localparam int DCNT_W  = $clog2(SUM_W + 1);
  localparam int TURN_MAX = 4;

  localparam logic [1:0] REG_BLOCK_SIZE   = 2'd0;
  localparam logic [1:0] REG_CLIP_VALUE   = 2'd1;
  localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd2;
  localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd3;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_TRACE = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SUM,
    ST_SUM_TAIL,
    ST_DIV,
    ST_FRONT,
    ST_SIDE,
    ST_DECIDE,
    ST_PUSH,
    ST_FINAL
  } state_t;

  typedef logic signed [1:0] delta_t;

  // Heading codes: 0 up, 1 right, 2 down, 3 left.
  localparam delta_t FWD_DX [4]   = '{2'sd0, 2'sd1, 2'sd0, -2'sd1};
  localparam delta_t FWD_DY [4]   = '{-2'sd1, 2'sd0, 2'sd1, 2'sd0};
  localparam delta_t LSIDE_DX [4] = '{-2'sd1, 2'sd1, 2'sd1, -2'sd1};
  localparam delta_t LSIDE_DY [4] = '{-2'sd1, -2'sd1, 2'sd1, 2'sd1};
  localparam delta_t RSIDE_DX [4] = '{2'sd1, 2'sd1, -2'sd1, -2'sd1};
  localparam delta_t RSIDE_DY [4] = '{-2'sd1, 2'sd1, 2'sd1, -2'sd1};

endpackage

@@ design/adaptive_maze_edge_tracer.sv @@
// Edge tracer top level: frame store, window-mean threshold sequencer and result register.
// A pixel write does not leave the idle state, so the block stays ready.
// A trace works each position through check, window sum at one pixel a cycle, sum tail,
// shift-subtract divide, front and side reads, decide and, if it steps, a push; a full
// result register stalls the push and the final item. The block takes no item while a
// trace runs. Reset (rst_n low) clears control state, not the frame store.
module adaptive_maze_edge_tracer import amet_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_operation,
  input  logic [8:0] in_coord_x,
  input  logic [7:0] in_coord_y,
  input  logic [7:0] in_pixel_value,
  input  logic       in_hand,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [8:0] out_edge_x,
  output logic [7:0] out_edge_y,
  output logic       out_point_valid,
  output logic       out_last_point,
  output logic [6:0] out_point_count,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [8:0] cfg_data
);

  logic [3:0] block_size_r;
  logic [7:0] clip_value_r;
  logic [8:0] image_width_r;
  logic [7:0] image_height_r;

  state_t state_r, state_nxt;

  logic [8:0] x_r, x_nxt;
  logic [7:0] y_r, y_nxt;
  logic [1:0] dir_r, dir_nxt;
  logic [2:0] turns_r, turns_nxt;
  logic [6:0] steps_r, steps_nxt;
  logic       hand_r, hand_nxt;
  logic [3:0] blk_r, blk_nxt;
  logic [2:0] half_r, half_nxt;
  logic [9:0] w_r, w_nxt;
  logic [8:0] h_r, h_nxt;
  logic [3:0] wi_r, wi_nxt, wj_r, wj_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [SUM_W-1:0] num_r, num_nxt;
  logic [DIV_W:0]   rem_r, rem_nxt;
  logic [DCNT_W-1:0] dcnt_r, dcnt_nxt;
  logic       rvld_r;
  logic [7:0] front_r, front_nxt;

  logic       pend_v_r, pend_v_nxt;
  logic [8:0] pend_x_r, pend_x_nxt;
  logic [7:0] pend_y_r, pend_y_nxt;
  logic [6:0] pend_n_r, pend_n_nxt;

  logic       out_valid_r, out_valid_nxt;
  logic [8:0] out_x_r, out_x_nxt;
  logic [7:0] out_y_r, out_y_nxt;
  logic       out_pv_r, out_pv_nxt;
  logic       out_last_r, out_last_nxt;
  logic [6:0] out_n_r, out_n_nxt;

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_r;
  logic       mem_we;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  logic [8:0] rd_x;
  logic [7:0] rd_y;

  logic       slot_free;
  logic       walk_ok;
  logic [DIV_W-1:0] divisor;
  logic [DIV_W:0]   rem_sh;
  logic signed [9:0] thr;
  logic       front_low, side_low;
  delta_t     sdx, sdy;
  logic [3:0] blk_in;

  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid       = out_valid_r;
  assign out_edge_x      = out_x_r;
  assign out_edge_y      = out_y_r;
  assign out_point_valid = out_pv_r;
  assign out_last_point  = out_last_r;
  assign out_point_count = out_n_r;

  assign slot_free = !out_valid_r || out_ready;
  assign divisor   = DIV_W'(blk_r) * DIV_W'(blk_r);
  assign rem_sh    = {rem_r[DIV_W-1:0], num_r[SUM_W-1]};
  assign thr       = $signed({2'b00, num_r[7:0]}) - $signed({2'b00, clip_value_r});
  assign front_low = $signed({2'b00, front_r}) < thr;
  assign side_low  = $signed({2'b00, rdata_r}) < thr;
  assign sdx = hand_r ? RSIDE_DX[dir_r] : LSIDE_DX[dir_r];
  assign sdy = hand_r ? RSIDE_DY[dir_r] : LSIDE_DY[dir_r];

  assign walk_ok = (steps_r < 7'(MAX_POINTS)) && (turns_r < 3'(TURN_MAX)) &&
                   ({6'd0, half_r} < {1'b0, x_r}) &&
                   ({1'b0, x_r} + {7'd0, half_r} + 10'd1 < w_r) &&
                   ({6'd0, half_r} < {1'b0, y_r}) &&
                   ({1'b0, y_r} + {6'd0, half_r} + 9'd1 < h_r);

  // Block size: low bit forced, floor at 3, ceiling at the largest window.
  always_comb begin
    blk_in = block_size_r | 4'd1;
    if (blk_in < 4'd3) blk_in = 4'd3;
    if (blk_in > 4'(MAX_BLOCK)) blk_in = 4'(MAX_BLOCK);
  end

  always_comb begin
    case (state_r)
      ST_FRONT: begin
        rd_x = x_r + {{7{FWD_DX[dir_r][1]}}, FWD_DX[dir_r]};
        rd_y = y_r + {{6{FWD_DY[dir_r][1]}}, FWD_DY[dir_r]};
      end
      ST_SIDE: begin
        rd_x = x_r + {{7{sdx[1]}}, sdx};
        rd_y = y_r + {{6{sdy[1]}}, sdy};
      end
      default: begin
        rd_x = x_r - {6'd0, half_r} + {5'd0, wi_r};
        rd_y = y_r - {5'd0, half_r} + {4'd0, wj_r};
      end
    endcase
  end

  assign rd_addr = ADDR_W'(rd_y) * ADDR_W'(MAX_WIDTH) + ADDR_W'(rd_x);
  assign wr_addr = ADDR_W'(in_coord_y) * ADDR_W'(MAX_WIDTH) + ADDR_W'(in_coord_x);
  assign mem_we  = in_valid && in_ready && (in_operation == OP_WRITE) &&
                   (in_coord_x < 9'(MAX_WIDTH)) && (in_coord_y < 8'(MAX_HEIGHT));

  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_addr] <= in_pixel_value;
    rdata_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_size_r   <= 4'd7;
      clip_value_r   <= 8'd0;
      image_width_r  <= 9'd320;
      image_height_r <= 8'd240;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_BLOCK_SIZE:   block_size_r   <= cfg_data[3:0];
        REG_CLIP_VALUE:   clip_value_r   <= cfg_data[7:0];
        REG_IMAGE_WIDTH:  image_width_r  <= cfg_data;
        REG_IMAGE_HEIGHT: image_height_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      x_r         <= '0;
      y_r         <= '0;
      dir_r       <= '0;
      turns_r     <= '0;
      steps_r     <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
      rvld_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      x_r         <= x_nxt;
      y_r         <= y_nxt;
      dir_r       <= dir_nxt;
      turns_r     <= turns_nxt;
      steps_r     <= steps_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
      rvld_r      <= (state_r == ST_SUM);
    end
  end

  always_ff @(posedge clk) begin
    hand_r     <= hand_nxt;
    blk_r      <= blk_nxt;
    half_r     <= half_nxt;
    w_r        <= w_nxt;
    h_r        <= h_nxt;
    wi_r       <= wi_nxt;
    wj_r       <= wj_nxt;
    sum_r      <= sum_nxt;
    num_r      <= num_nxt;
    rem_r      <= rem_nxt;
    dcnt_r     <= dcnt_nxt;
    front_r    <= front_nxt;
    pend_x_r   <= pend_x_nxt;
    pend_y_r   <= pend_y_nxt;
    pend_n_r   <= pend_n_nxt;
    out_x_r    <= out_x_nxt;
    out_y_r    <= out_y_nxt;
    out_pv_r   <= out_pv_nxt;
    out_last_r <= out_last_nxt;
    out_n_r    <= out_n_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    x_nxt = x_r;  y_nxt = y_r;  dir_nxt = dir_r;
    turns_nxt = turns_r;  steps_nxt = steps_r;  hand_nxt = hand_r;
    blk_nxt = blk_r;  half_nxt = half_r;  w_nxt = w_r;  h_nxt = h_r;
    wi_nxt = wi_r;  wj_nxt = wj_r;  sum_nxt = sum_r;
    num_nxt = num_r;  rem_nxt = rem_r;  dcnt_nxt = dcnt_r;  front_nxt = front_r;
    pend_v_nxt = pend_v_r;  pend_x_nxt = pend_x_r;
    pend_y_nxt = pend_y_r;  pend_n_nxt = pend_n_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_x_nxt = out_x_r;  out_y_nxt = out_y_r;  out_pv_nxt = out_pv_r;
    out_last_nxt = out_last_r;  out_n_nxt = out_n_r;

    if (rvld_r) sum_nxt = sum_r + SUM_W'(rdata_r);

    case (state_r)
      ST_IDLE: begin
        if (in_valid && in_operation == OP_TRACE) begin
          x_nxt = in_coord_x;
          y_nxt = in_coord_y;
          dir_nxt = 2'd0;
          turns_nxt = 3'd0;
          steps_nxt = 7'd0;
          hand_nxt = in_hand;
          blk_nxt = blk_in;
          half_nxt = blk_in[3:1];
          w_nxt = (image_width_r > 9'(MAX_WIDTH)) ? 10'(MAX_WIDTH) : {1'b0, image_width_r};
          h_nxt = ({1'b0, image_height_r} > 9'(MAX_HEIGHT)) ? 9'(MAX_HEIGHT)
                                                           : {1'b0, image_height_r};
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        wi_nxt = 4'd0;
        wj_nxt = 4'd0;
        sum_nxt = '0;
        state_nxt = walk_ok ? ST_SUM : ST_FINAL;
      end
      ST_SUM: begin
        if (wi_r == blk_r - 4'd1) begin
          wi_nxt = 4'd0;
          if (wj_r == blk_r - 4'd1) state_nxt = ST_SUM_TAIL;
          else wj_nxt = wj_r + 4'd1;
        end else begin
          wi_nxt = wi_r + 4'd1;
        end
      end
      ST_SUM_TAIL: begin
        num_nxt = sum_nxt;
        rem_nxt = '0;
        dcnt_nxt = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        // One quotient bit per cycle; num_r ends up holding the quotient.
        if (rem_sh >= {1'b0, divisor}) begin
          rem_nxt = rem_sh - {1'b0, divisor};
          num_nxt = {num_r[SUM_W-2:0], 1'b1};
        end else begin
          rem_nxt = rem_sh;
          num_nxt = {num_r[SUM_W-2:0], 1'b0};
        end
        dcnt_nxt = dcnt_r + DCNT_W'(1);
        if (dcnt_r == DCNT_W'(SUM_W - 1)) state_nxt = ST_FRONT;
      end
      ST_FRONT: state_nxt = ST_SIDE;
      ST_SIDE: begin
        front_nxt = rdata_r;
        state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (front_low) begin
          dir_nxt = dir_r + (hand_r ? 2'd3 : 2'd1);
          turns_nxt = turns_r + 3'd1;
          state_nxt = ST_CHECK;
        end else begin
          if (side_low) begin
            x_nxt = x_r + {{7{FWD_DX[dir_r][1]}}, FWD_DX[dir_r]};
            y_nxt = y_r + {{6{FWD_DY[dir_r][1]}}, FWD_DY[dir_r]};
          end else begin
            x_nxt = x_r + {{7{sdx[1]}}, sdx};
            y_nxt = y_r + {{6{sdy[1]}}, sdy};
            dir_nxt = dir_r + (hand_r ? 2'd1 : 2'd3);
          end
          steps_nxt = steps_r + 7'd1;
          turns_nxt = 3'd0;
          state_nxt = ST_PUSH;
        end
      end
      ST_PUSH: begin
        // The held point is known not to be the last one once a newer point exists.
        if (!pend_v_r || slot_free) begin
          if (pend_v_r) begin
            out_valid_nxt = 1'b1;
            out_x_nxt = pend_x_r;
            out_y_nxt = pend_y_r;
            out_pv_nxt = 1'b1;
            out_last_nxt = 1'b0;
            out_n_nxt = pend_n_r;
          end
          pend_v_nxt = 1'b1;
          pend_x_nxt = x_r;
          pend_y_nxt = y_r;
          pend_n_nxt = steps_r;
          state_nxt = ST_CHECK;
        end
      end
      ST_FINAL: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_x_nxt = pend_v_r ? pend_x_r : 9'd0;
          out_y_nxt = pend_v_r ? pend_y_r : 8'd0;
          out_pv_nxt = pend_v_r;
          out_last_nxt = 1'b1;
          out_n_nxt = pend_v_r ? pend_n_r : 7'd0;
          pend_v_nxt = 1'b0;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !pend_v_r)
    else $error("held point left over after a trace ended");

  a_step_limit: assert property (@(posedge clk) disable iff (!rst_n)
    steps_r <= 7'(MAX_POINTS))
    else $error("step count beyond the point limit");

  a_turn_limit: assert property (@(posedge clk) disable iff (!rst_n)
    turns_r <= 3'(TURN_MAX))
    else $error("turn run beyond four");

  a_final_last: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FINAL && state_nxt == ST_IDLE) |=> (out_valid_r && out_last_r))
    else $error("trace ended without a last item");

endmodule
